>>> sv/anbsf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the annex-b splitter and framer
package anbsf_pkg;

	// frame counter width and derived arithmetic widths
	localparam int CNT_W   = 32;
	localparam int IDX_W   = 32;
	localparam int TS_W    = 63;
	localparam int FPS_W   = 16;
	localparam int TICKS_W = 24;
	localparam int K_W     = FPS_W + TICKS_W;
	localparam int K_HALF  = K_W / 2;
	localparam int PROD_W  = CNT_W + K_W;
	localparam int DIVC_W  = $clog2(PROD_W);

	localparam logic [TICKS_W-1:0] TICKS_PER_SEC = TICKS_W'(10000000);

	// input kinds
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// configuration register indexes
	localparam logic CFG_FPS_NUM = 1'b0;
	localparam logic CFG_FPS_DEN = 1'b1;

	localparam logic [FPS_W-1:0] FPS_NUM_RST = FPS_W'(30);
	localparam logic [FPS_W-1:0] FPS_DEN_RST = FPS_W'(1);

	// nal unit types of interest
	localparam logic [4:0] NAL_SLICE = 5'd1;
	localparam logic [4:0] NAL_IDR   = 5'd5;
	localparam logic [4:0] NAL_SPS   = 5'd7;
	localparam logic [4:0] NAL_PPS   = 5'd8;
	localparam logic [7:0] TYPE_MASK = 8'h1f;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;

	// one event from the parser: maybe a payload byte, maybe the unit end
	typedef struct packed {
		logic       has_byte;
		logic [7:0] data;
		logic       last;
	} ev_t;

	// one result item
	typedef struct packed {
		logic             byte_valid;
		logic [7:0]       payload_byte;
		logic             nal_end;
		logic [4:0]       nal_kind;
		logic             is_frame;
		logic             key_frame;
		logic [IDX_W-1:0] frame_seq;
		logic [TS_W-1:0]  timestamp;
	} res_t;

	// frame rate settings handed to the framer
	typedef struct packed {
		logic [FPS_W-1:0] fps_num;
		logic [FPS_W-1:0] fps_den;
	} fps_cfg_t;

endpackage

>>> sv/anbsf_front.sv
`timescale 1ns / 1ps
// byte parser: start code sync, three byte hold-back, event generation
module anbsf_front import anbsf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output logic       ev_push,
	output ev_t        ev_data,
	input  logic       ev_full
);

	logic [7:0] held_q [3];
	logic [1:0] held_cnt_q;
	logic [1:0] zrun_q;
	logic       in_unit_q;
	logic       nonempty_q;
	ev_t        pend_q [3];
	logic [1:0] pend_cnt_q;

	logic [7:0] held_d [3];
	logic [1:0] held_cnt_d;
	logic [1:0] zrun_d;
	logic       in_unit_d;
	logic       nonempty_d;
	ev_t        ev_d [3];
	logic [1:0] ev_n;
	logic       accept;
	logic       is_start;

	// pending events drain one per cycle while the event queue is not full
	assign ev_push = (pend_cnt_q != 2'd0) && !ev_full;
	assign ev_data = pend_q[0];
	assign full    = !((pend_cnt_q == 2'd0) || ((pend_cnt_q == 2'd1) && !ev_full));
	assign accept  = push && !full;

	assign is_start = (data_byte == BYTE_ONE) &&
		(((held_cnt_q == 2'd2) && (held_q[0] == BYTE_ZERO) && (held_q[1] == BYTE_ZERO)) ||
		 ((held_cnt_q == 2'd3) && (held_q[1] == BYTE_ZERO) && (held_q[2] == BYTE_ZERO)));

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			held_d[i] = held_q[i];
			ev_d[i]   = '0;
		end
		held_cnt_d = held_cnt_q;
		zrun_d     = zrun_q;
		in_unit_d  = in_unit_q;
		nonempty_d = nonempty_q;
		ev_n       = 2'd0;
		if (kind == KIND_FLUSH) begin
			if (in_unit_q) begin
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < held_cnt_q) begin
						ev_d[i].has_byte = 1'b1;
						ev_d[i].data     = held_q[i];
						ev_d[i].last     = (2'(i + 1) == held_cnt_q);
					end
				end
				ev_n = held_cnt_q;
				if ((held_cnt_q == 2'd0) && nonempty_q) begin
					ev_d[0].last = 1'b1;
					ev_n         = 2'd1;
				end
			end
			held_cnt_d = 2'd0;
			nonempty_d = 1'b0;
			in_unit_d  = 1'b0;
			zrun_d     = 2'd0;
		end else if (!in_unit_q) begin
			if (data_byte == BYTE_ZERO) begin
				if (zrun_q != 2'd2) begin
					zrun_d = zrun_q + 2'd1;
				end
			end else begin
				if ((data_byte == BYTE_ONE) && (zrun_q == 2'd2)) begin
					in_unit_d  = 1'b1;
					held_cnt_d = 2'd0;
					nonempty_d = 1'b0;
				end
				zrun_d = 2'd0;
			end
		end else if (is_start) begin
			// a leading zero of a four byte code is dropped
			if ((held_cnt_q == 2'd3) && (held_q[0] != BYTE_ZERO)) begin
				ev_d[0].has_byte = 1'b1;
				ev_d[0].data     = held_q[0];
				ev_d[0].last     = 1'b1;
				ev_n             = 2'd1;
			end else if (nonempty_q) begin
				ev_d[0].last = 1'b1;
				ev_n         = 2'd1;
			end
			held_cnt_d = 2'd0;
			nonempty_d = 1'b0;
		end else if (held_cnt_q == 2'd3) begin
			ev_d[0].has_byte = 1'b1;
			ev_d[0].data     = held_q[0];
			ev_n             = 2'd1;
			nonempty_d       = 1'b1;
			held_d[0]        = held_q[1];
			held_d[1]        = held_q[2];
			held_d[2]        = data_byte;
		end else begin
			held_d[held_cnt_q] = data_byte;
			held_cnt_d         = held_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				held_q[i] <= BYTE_ZERO;
			end
			held_cnt_q <= 2'd0;
			zrun_q     <= 2'd0;
			in_unit_q  <= 1'b0;
			nonempty_q <= 1'b0;
			pend_cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				held_q     <= held_d;
				held_cnt_q <= held_cnt_d;
				zrun_q     <= zrun_d;
				in_unit_q  <= in_unit_d;
				nonempty_q <= nonempty_d;
				pend_cnt_q <= ev_n;
			end else if (ev_push) begin
				pend_cnt_q <= pend_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= ev_d;
		end else if (ev_push) begin
			pend_q[0] <= pend_q[1];
			pend_q[1] <= pend_q[2];
		end
	end

endmodule

>>> sv/anbsf_evq.sv
`timescale 1ns / 1ps
// four entry event queue between parser and framer
module anbsf_evq import anbsf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  ev_t  wr_data,
	output logic full,
	input  logic rd_en,
	output ev_t  rd_data,
	output logic empty
);

	ev_t        mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (cnt_q == 3'd4);
	assign empty   = (cnt_q == 3'd0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> sv/anbsf_back.sv
`timescale 1ns / 1ps
// framer: unit type tracking, frame counting, timestamp divider, result queue
module anbsf_back import anbsf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fps_cfg_t cfg,
	input  ev_t      ev,
	input  logic     ev_empty,
	output logic     ev_pop,
	input  logic     pop,
	output logic     empty,
	output res_t     res
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL_LO = 5'b00010,
		ST_MUL_HI = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t              state_q;
	logic [4:0]          type_q;
	logic                nonempty_q;
	logic                have_sps_q;
	logic                have_pps_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [K_W-1:0]      k_q;
	logic [PROD_W-1:0]   prod_q;
	logic [FPS_W-1:0]    rem_q;
	logic [DIVC_W-1:0]   div_cnt_q;
	res_t                hold_q;
	res_t                out_mem_q [2];
	logic                out_wr_q;
	logic                out_rd_q;
	logic [1:0]          out_cnt_q;

	logic                out_full;
	logic                out_push;
	res_t                out_data;
	logic [4:0]          type_eff;
	logic                is_frame;
	logic                is_key;
	res_t                res_new;
	logic [K_HALF-1:0]   mul_b;
	logic [CNT_W+K_HALF-1:0] mul_p;
	logic [FPS_W:0]      rem_sh;
	logic                rem_ge;
	logic [FPS_W:0]      rem_diff;
	logic [PROD_W+TS_W-1:0] quo_x;
	logic                ts_sat;
	logic [TS_W-1:0]     ts_val;
	logic                out_pop;

	assign out_full = (out_cnt_q == 2'd2);
	assign empty    = (out_cnt_q == 2'd0);
	assign res      = out_mem_q[out_rd_q];
	assign out_pop  = pop && !empty;

	assign ev_pop = (state_q == ST_IDLE) && !ev_empty && !out_full;

	// type comes from the first payload byte of the unit
	assign type_eff = (ev.has_byte && !nonempty_q) ? ev.data[4:0] : type_q;
	assign is_frame = ev.last && ((type_eff == NAL_SLICE) || (type_eff == NAL_IDR));
	assign is_key   = ev.last && (type_eff == NAL_IDR) && have_sps_q && have_pps_q;

	always_comb begin
		res_new              = '0;
		res_new.byte_valid   = ev.has_byte;
		res_new.payload_byte = ev.has_byte ? ev.data : BYTE_ZERO;
		res_new.nal_end      = ev.last;
		res_new.nal_kind     = ev.last ? type_eff : 5'd0;
		res_new.is_frame     = is_frame;
		res_new.key_frame    = is_key;
		res_new.frame_seq    = is_frame ? IDX_W'(cnt_q) : '0;
	end

	// shared multiplier over the two halves of k
	assign mul_b = (state_q == ST_MUL_LO) ? k_q[K_HALF-1:0] : k_q[K_W-1:K_HALF];
	assign mul_p = cnt_q * mul_b;

	// restoring division, one quotient bit per cycle
	assign rem_sh   = {rem_q, prod_q[PROD_W-1]};
	assign rem_ge   = (rem_sh >= {1'b0, cfg.fps_num});
	assign rem_diff = rem_sh - {1'b0, cfg.fps_num};

	assign quo_x  = {{TS_W{1'b0}}, prod_q};
	assign ts_sat = |(quo_x >> TS_W);
	assign ts_val = ts_sat ? {TS_W{1'b1}} : quo_x[TS_W-1:0];

	always_comb begin
		out_push = 1'b0;
		out_data = res_new;
		if (ev_pop && !is_frame) begin
			out_push = 1'b1;
		end else if ((state_q == ST_DONE) && !out_full) begin
			out_push = 1'b1;
			out_data = hold_q;
			out_data.timestamp = ts_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			type_q     <= 5'd0;
			nonempty_q <= 1'b0;
			have_sps_q <= 1'b0;
			have_pps_q <= 1'b0;
			cnt_q      <= '0;
			out_wr_q   <= 1'b0;
			out_rd_q   <= 1'b0;
			out_cnt_q  <= 2'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ev_pop) begin
						if (ev.has_byte && !nonempty_q) begin
							type_q     <= ev.data[4:0];
							nonempty_q <= 1'b1;
						end
						if (ev.last) begin
							nonempty_q <= 1'b0;
							if (type_eff == NAL_SPS) begin
								have_sps_q <= 1'b1;
							end
							if (type_eff == NAL_PPS) begin
								have_pps_q <= 1'b1;
							end
						end
						if (is_frame) begin
							state_q <= ST_MUL_LO;
						end
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_cnt_q == DIVC_W'(0)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_full) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_push) begin
				out_wr_q <= ~out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= ~out_rd_q;
			end
			case ({out_push, out_pop})
				2'b10:   out_cnt_q <= out_cnt_q + 2'd1;
				2'b01:   out_cnt_q <= out_cnt_q - 2'd1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop && is_frame) begin
			hold_q <= res_new;
			k_q    <= K_W'(cfg.fps_den * TICKS_PER_SEC);
		end
		case (state_q)
			ST_MUL_LO: prod_q <= PROD_W'(mul_p);
			ST_MUL_HI: begin
				prod_q    <= prod_q + (PROD_W'(mul_p) << K_HALF);
				rem_q     <= '0;
				div_cnt_q <= DIVC_W'(PROD_W - 1);
			end
			ST_DIV: begin
				prod_q    <= {prod_q[PROD_W-2:0], rem_ge};
				rem_q     <= rem_ge ? rem_diff[FPS_W-1:0] : rem_sh[FPS_W-1:0];
				div_cnt_q <= div_cnt_q - DIVC_W'(1);
			end
			default: prod_q <= prod_q;
		endcase
		if (out_push) begin
			out_mem_q[out_wr_q] <= out_data;
		end
	end

endmodule

>>> sv/annexb_nal_splitter_framer.sv
`timescale 1ns / 1ps
// top level of the annex-b nal splitter and framer
//
// input channel: one request per stream byte (kind 0) or end-of-stream flush
// (kind 1), taken at a clock edge with push high and full low
// result channel: the oldest result sits on the result ports while empty is
// low and is taken at a clock edge with pop high and empty low
// config channel: cfg_index 0 writes fps_num, 1 writes fps_den, taken when
// cfg_valid and cfg_ready are high; cfg_ready is always high
// throughput: one stream byte per cycle while the framer is free; a
// flush hands on up to three events, and the input stalls meanwhile
// hold-back: a payload byte leaves once three later bytes have arrived and
// passes the parser's pending slots, the event queue and a result slot
// slice end: the framer is busy with the pop, the low and high multiply
// steps, a 72-bit bit-serial divide and the write-out, and full rises
// once five further events wait
// reset: unsynchronized, nothing held, counter and sps/pps flags cleared,
// fps_num 30 and fps_den 1
// stall: when pop stays low the two result slots fill, the framer stops,
// the event queue fills and full rises; nothing is lost
module annexb_nal_splitter_framer import anbsf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// input requests
	input  logic             push,
	output logic             full,
	input  logic             kind,
	input  logic [7:0]       data_byte,
	// result requests
	output logic             empty,
	input  logic             pop,
	output logic             byte_valid,
	output logic [7:0]       payload_byte,
	output logic             nal_end,
	output logic [4:0]       nal_kind,
	output logic             is_frame,
	output logic             key_frame,
	output logic [IDX_W-1:0] frame_seq,
	output logic [TS_W-1:0]  timestamp,
	// configuration writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [FPS_W-1:0] cfg_data
);

	fps_cfg_t cfg_q;
	ev_t      fe_ev;
	logic     fe_push;
	logic     q_full;
	ev_t      q_ev;
	logic     q_empty;
	logic     q_pop;
	res_t     res;

	// registers are always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fps_num <= FPS_NUM_RST;
			cfg_q.fps_den <= FPS_DEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FPS_NUM: cfg_q.fps_num <= cfg_data;
				CFG_FPS_DEN: cfg_q.fps_den <= cfg_data;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	// parser: sync, hold-back, start code removal
	anbsf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.data_byte (data_byte),
		.ev_push   (fe_push),
		.ev_data   (fe_ev),
		.ev_full   (q_full)
	);

	// decouples the byte rate from the timestamp divider
	anbsf_evq u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fe_push),
		.wr_data (fe_ev),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_ev),
		.empty   (q_empty)
	);

	// framer and result queue
	anbsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.ev       (q_ev),
		.ev_empty (q_empty),
		.ev_pop   (q_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign byte_valid   = res.byte_valid;
	assign payload_byte = res.payload_byte;
	assign nal_end      = res.nal_end;
	assign nal_kind     = res.nal_kind;
	assign is_frame     = res.is_frame;
	assign key_frame    = res.key_frame;
	assign frame_seq    = res.frame_seq;
	assign timestamp    = res.timestamp;

endmodule
